FILE: rtl/itrd_pkg.sv
// itrd_pkg: shared widths, reset values, register indexes, command/status structs
// and the radix clamp and character lookup helpers for the integer to radix digits converter
// no dependencies
package itrd_pkg;

    localparam int VALUE_BITS  = 32;
    localparam int MAX_RADIX   = 32;
    localparam int RADIX_W     = 6;
    localparam int CFG_WORD_W  = 64;
    localparam int ALPHA_WORDS = 4;
    localparam int CHAR_W      = 8;
    localparam int ALPHA_CHARS = ALPHA_WORDS * CFG_WORD_W / CHAR_W;
    localparam int ALPHA_IDX_W = $clog2(ALPHA_CHARS);
    localparam int DIGIT_W     = $clog2(MAX_RADIX);
    localparam int CMP_W       = DIGIT_W + 1;
    localparam int ERADIX_W    = $clog2(MAX_RADIX + 1);
    localparam int NUM_DIGITS  = VALUE_BITS;
    localparam int LEN_W       = $clog2(NUM_DIGITS + 1);
    localparam int PTR_W       = $clog2(NUM_DIGITS);
    localparam int BIT_CNT_W   = $clog2(VALUE_BITS);
    localparam int CFG_IDX_W   = 3;
    localparam int ASEL_W      = $clog2(ALPHA_WORDS);

    typedef logic [ALPHA_WORDS-1:0][CFG_WORD_W-1:0] t_alphabet;

    localparam logic [RADIX_W-1:0] RADIX_RESET = RADIX_W'(10);
    localparam t_alphabet ALPHA_RESET = {
        64'd0, 64'd0, 64'd14648, 64'd3978425819141910832
    };
    localparam logic [CHAR_W-1:0] MINUS_CHAR = 8'h2D;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_RADIX   = 3'd0,
        CFG_ALPHA_0 = 3'd1,
        CFG_ALPHA_1 = 3'd2,
        CFG_ALPHA_2 = 3'd3,
        CFG_ALPHA_3 = 3'd4
    } t_cfg_idx;

    typedef struct packed {
        logic load;
        logic shift;
        logic emit_sign;
        logic emit_digit;
    } t_cmd;

    typedef struct packed {
        logic neg;
        logic conv_last;
        logic digit_last;
    } t_status;

    // clamp the programmed radix into 2..MAX_RADIX
    function automatic logic [ERADIX_W-1:0] eff_radix(input logic [RADIX_W-1:0] r);
        logic [ERADIX_W-1:0] res;
        if (r < RADIX_W'(2)) begin
            res = ERADIX_W'(2);
        end else if (32'(r) > MAX_RADIX) begin
            res = ERADIX_W'(MAX_RADIX);
        end else begin
            res = ERADIX_W'(r);
        end
        return res;
    endfunction

    // digit to character, zero beyond the alphabet
    function automatic logic [CHAR_W-1:0] alpha_char(input t_alphabet a,
                                                     input logic [DIGIT_W-1:0] d);
        logic [ALPHA_CHARS-1:0][CHAR_W-1:0] chars;
        logic [DIGIT_W+ALPHA_IDX_W-1:0]     ext;
        logic [CHAR_W-1:0]                  res;
        chars = a;
        ext   = {{ALPHA_IDX_W{1'b0}}, d};
        if (ext >= (DIGIT_W+ALPHA_IDX_W)'(ALPHA_CHARS)) begin
            res = '0;
        end else begin
            res = chars[ext[ALPHA_IDX_W-1:0]];
        end
        return res;
    endfunction

endpackage

FILE: rtl/itrd_ctrl.sv
// itrd_ctrl: sequencer for one conversion (load, bit shifting, sign, digits)
// depends on itrd_pkg
module itrd_ctrl
    import itrd_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_start,
    input  t_status i_status,
    output t_cmd    o_cmd,
    output logic    o_busy
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CONV,
        ST_SIGN,
        ST_DIGITS
    } t_state;

    t_state r_state, n_state;
    logic   r_busy;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_start) n_state = ST_CONV;
            end
            ST_CONV: begin
                if (i_status.conv_last) n_state = i_status.neg ? ST_SIGN : ST_DIGITS;
            end
            ST_SIGN: begin
                n_state = ST_DIGITS;
            end
            ST_DIGITS: begin
                if (i_status.digit_last) n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_busy  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_busy  <= (n_state != ST_IDLE);
        end
    end

    assign o_busy           = r_busy;
    assign o_cmd.load       = (r_state == ST_IDLE) && i_start;
    assign o_cmd.shift      = (r_state == ST_CONV);
    assign o_cmd.emit_sign  = (r_state == ST_SIGN);
    assign o_cmd.emit_digit = (r_state == ST_DIGITS);

    a_cmd_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({o_cmd.load, o_cmd.shift, o_cmd.emit_sign, o_cmd.emit_digit}))
        else $error("more than one datapath command at once");

    a_busy_ends_on_last_digit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(o_busy) |-> $past(r_state == ST_DIGITS && i_status.digit_last))
        else $error("busy dropped before the last digit went out");

    a_busy_tracks_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_busy == (r_state != ST_IDLE))
        else $error("busy flag out of step with the sequencer");

endmodule

FILE: rtl/itrd_dpath.sv
// itrd_dpath: magnitude shifter, row of radix digit cells, digit pointer and
// character output register; depends on itrd_pkg
module itrd_dpath
    import itrd_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_cmd                     i_cmd,
    input  logic signed [VALUE_BITS-1:0] i_value,
    input  logic [RADIX_W-1:0]       i_radix,
    input  t_alphabet                i_alphabet,
    output t_status                  o_status,
    output logic                     o_valid,
    output logic [CHAR_W-1:0]        o_character,
    output logic                     o_last
);

    logic [VALUE_BITS-1:0]                r_mag;
    logic                                 r_neg;
    logic [ERADIX_W-1:0]                  r_radix;
    logic [NUM_DIGITS-1:0][DIGIT_W-1:0]   r_cells, n_cells;
    logic [LEN_W-1:0]                     r_len, n_len;
    logic [PTR_W-1:0]                     r_ptr;
    logic [BIT_CNT_W-1:0]                 r_bit_cnt;
    logic                                 r_valid;
    logic [CHAR_W-1:0]                    r_character;
    logic                                 r_last;

    logic [NUM_DIGITS:0]                  carry;
    logic [NUM_DIGITS-1:0]                gen, prop;
    logic [NUM_DIGITS-1:0][CMP_W-1:0]     dbl, dbl_in, dbl_sub;
    logic [CMP_W-1:0]                     radix_cmp;
    logic [VALUE_BITS-1:0]                in_mag;
    logic [DIGIT_W-1:0]                   rd_digit;

    assign radix_cmp = CMP_W'(r_radix);
    assign in_mag    = i_value[VALUE_BITS-1] ? (VALUE_BITS'(0) - VALUE_BITS'(i_value))
                                             : VALUE_BITS'(i_value);

    // each cell doubles its digit and adds the carry from below; a carry out
    // means the doubled digit plus the carry in reached the radix
    always_comb begin
        for (int i = 0; i < NUM_DIGITS; i++) begin
            dbl[i]  = {r_cells[i], 1'b0};
            gen[i]  = dbl[i] >= radix_cmp;
            prop[i] = (dbl[i] | CMP_W'(1)) >= radix_cmp;
        end
        carry[0] = r_mag[VALUE_BITS-1];
        for (int i = 0; i < NUM_DIGITS; i++) begin
            carry[i+1] = gen[i] | (prop[i] & carry[i]);
        end
        for (int i = 0; i < NUM_DIGITS; i++) begin
            dbl_in[i]  = dbl[i] | CMP_W'(carry[i]);
            dbl_sub[i] = dbl_in[i] - radix_cmp;
            n_cells[i] = carry[i+1] ? dbl_sub[i][DIGIT_W-1:0] : dbl_in[i][DIGIT_W-1:0];
        end
    end

    assign n_len    = r_len + LEN_W'(carry[r_len]);
    assign rd_digit = r_cells[r_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len     <= LEN_W'(1);
            r_ptr     <= '0;
            r_bit_cnt <= '0;
            r_valid   <= 1'b0;
        end else begin
            r_valid <= i_cmd.emit_sign || i_cmd.emit_digit;
            if (i_cmd.load) begin
                r_len     <= LEN_W'(1);
                r_ptr     <= '0;
                r_bit_cnt <= '0;
            end else if (i_cmd.shift) begin
                r_len     <= n_len;
                r_ptr     <= PTR_W'(n_len - LEN_W'(1));
                r_bit_cnt <= r_bit_cnt + BIT_CNT_W'(1);
            end else if (i_cmd.emit_digit && (r_ptr != '0)) begin
                r_ptr <= r_ptr - PTR_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_mag   <= in_mag;
            r_neg   <= i_value[VALUE_BITS-1];
            r_radix <= eff_radix(i_radix);
            r_cells <= '0;
        end else if (i_cmd.shift) begin
            r_mag   <= {r_mag[VALUE_BITS-2:0], 1'b0};
            r_cells <= n_cells;
        end
        if (i_cmd.emit_sign) begin
            r_character <= MINUS_CHAR;
            r_last      <= 1'b0;
        end else if (i_cmd.emit_digit) begin
            r_character <= alpha_char(i_alphabet, rd_digit);
            r_last      <= (r_ptr == '0);
        end
    end

    assign o_status.neg        = r_neg;
    assign o_status.conv_last  = (r_bit_cnt == BIT_CNT_W'(VALUE_BITS - 1));
    assign o_status.digit_last = (r_ptr == '0);
    assign o_valid             = r_valid;
    assign o_character         = r_character;
    assign o_last              = r_last;

    a_digit_below_radix: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit_digit |-> (CMP_W'(rd_digit) < radix_cmp))
        else $error("emitted digit not below the radix");

    a_ptr_inside_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        LEN_W'(r_ptr) < r_len)
        else $error("digit pointer beyond the digit count");

    a_no_top_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.shift |-> !carry[NUM_DIGITS])
        else $error("digit row overflowed");

endmodule

FILE: rtl/integer_to_radix_digits_top.sv
// integer_to_radix_digits_top: one accepted value gives (value is negative) + (digit count)
// characters, one per cycle; the accepting edge loads the value, which is then fed
// through the digit row one magnitude bit per shift before the first character appears
// busy is high through the shifts, optional sign and digits; start is taken once busy is low
// results cannot be held off; synchronous active-low reset, radix 10 and "0123456789"
// depends on itrd_pkg, itrd_ctrl, itrd_dpath
module integer_to_radix_digits_top
    import itrd_pkg::*;
(
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // command transaction
    input  logic                         start,
    output logic                         busy,
    input  logic signed [VALUE_BITS-1:0] i_value,
    // configuration writes
    input  logic                         i_cfg_we,
    input  logic [CFG_IDX_W-1:0]         i_cfg_idx,
    input  logic [CFG_WORD_W-1:0]        i_cfg_wdata,
    // character transactions
    output logic                         o_valid,
    output logic [CHAR_W-1:0]            o_character,
    output logic                         o_last
);

    // configuration registers
    logic [RADIX_W-1:0] r_radix;
    t_alphabet          r_alphabet;
    logic [CFG_IDX_W-1:0] alpha_sel;

    // control/status between sequencer and datapath
    t_cmd    cmd;
    t_status status;

    // alphabet word index from the register index
    assign alpha_sel = i_cfg_idx - CFG_IDX_W'(CFG_ALPHA_0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radix    <= RADIX_RESET;
            r_alphabet <= ALPHA_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx) inside
                CFG_RADIX: begin
                    r_radix <= i_cfg_wdata[RADIX_W-1:0];
                end
                CFG_ALPHA_0, CFG_ALPHA_1, CFG_ALPHA_2, CFG_ALPHA_3: begin
                    r_alphabet[alpha_sel[ASEL_W-1:0]] <= i_cfg_wdata;
                end
                default: begin
                    // unknown register index, write dropped
                end
            endcase
        end
    end

    // sequencer: load, one shift per magnitude bit, optional sign, digits
    itrd_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_status (status),
        .o_cmd    (cmd),
        .o_busy   (busy)
    );

    // datapath: digit row fed msb first, then read back from the top digit down
    itrd_dpath u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_value     (i_value),
        .i_radix     (r_radix),
        .i_alphabet  (r_alphabet),
        .o_status    (status),
        .o_valid     (o_valid),
        .o_character (o_character),
        .o_last      (o_last)
    );

    // no character directly follows the last one of a transaction
    a_gap_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_last) |=> !o_valid)
        else $error("character straight after the final one");

    // characters only appear while a conversion is in flight or just finished
    a_valid_needs_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(busy))
        else $error("character without a conversion in progress");

endmodule

FILE: verif/tb_integer_to_radix_digits_top.sv
// testbench for integer_to_radix_digits_top: drives signed values and register writes,
// predicts every output character and checks each one as it leaves the block
// depends on itrd_pkg and integer_to_radix_digits_top
`timescale 1ns / 1ps

module tb_integer_to_radix_digits_top;
    import itrd_pkg::*;

    // quiet cycles tolerated before the run is declared hung
    localparam int WATCHDOG_LIMIT = 2000;
    // cycles allowed after the last character for stray output
    localparam int DRAIN_CYCLES   = 80;
    localparam int RANDOM_PHASES  = 10;
    localparam int VALUES_PER_PHASE = 38;

    typedef struct packed {
        logic [CHAR_W-1:0] ch;
        logic              last;
    } t_char_exp;

    logic                         i_clk;
    logic                         i_rst_n;
    logic                         start;
    logic                         busy;
    logic signed [VALUE_BITS-1:0] i_value;
    logic                         i_cfg_we;
    logic [CFG_IDX_W-1:0]         i_cfg_idx;
    logic [CFG_WORD_W-1:0]        i_cfg_wdata;
    logic                         o_valid;
    logic [CHAR_W-1:0]            o_character;
    logic                         o_last;

    // shadow copy of the configuration registers
    logic [RADIX_W-1:0] cur_radix;
    t_alphabet          cur_alphabet;

    // characters predicted but not yet seen, oldest first
    t_char_exp pending_chars[$];

    int  error_count;
    int  values_sent;
    int  chars_seen;
    int  cfg_writes;
    int  quiet_cycles;
    // when set, the sender never idles
    bit  burst_mode;

    integer_to_radix_digits_top DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_value     (i_value),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .o_valid     (o_valid),
        .o_character (o_character),
        .o_last      (o_last)
    );

    // 10 ns clock
    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    task automatic report_mismatch(input string what);
        error_count++;
        $display("[%0t] mismatch: %s", $realtime, what);
    endtask

    // radix as the block uses it: clamped into 2..MAX_RADIX
    function automatic int digit_base();
        if (cur_radix < 2) begin
            return 2;
        end
        if (int'(cur_radix) > MAX_RADIX) begin
            return MAX_RADIX;
        end
        return int'(cur_radix);
    endfunction

    // alphabet lookup, lowest byte of word 0 is digit 0
    function automatic logic [CHAR_W-1:0] digit_char(input int idx);
        if (idx >= ALPHA_CHARS) begin
            return '0;
        end
        return cur_alphabet[idx / 8][(idx % 8) * CHAR_W +: CHAR_W];
    endfunction

    // expected characters for one accepted value, most significant digit first
    task automatic queue_digits(input logic signed [VALUE_BITS-1:0] v);
        logic [VALUE_BITS-1:0] mag;
        logic [VALUE_BITS-1:0] base;
        logic                  neg;
        int                    digs[$];
        t_char_exp             c;
        neg  = v[VALUE_BITS-1];
        mag  = v;
        base = VALUE_BITS'(digit_base());
        // two's complement magnitude; the most negative value maps onto itself
        if (neg) begin
            mag = ~mag + 1'b1;
        end
        if (mag == '0) begin
            c.ch   = digit_char(0);
            c.last = 1'b1;
            pending_chars.push_back(c);
            return;
        end
        while (mag != '0) begin
            digs.push_back(int'(mag % base));
            mag = mag / base;
        end
        if (neg) begin
            c.ch   = MINUS_CHAR;
            c.last = 1'b0;
            pending_chars.push_back(c);
        end
        for (int k = digs.size() - 1; k >= 0; k--) begin
            c.ch   = digit_char(digs[k]);
            c.last = (k == 0);
            pending_chars.push_back(c);
        end
    endtask

    // one register write, shadow updated alongside; unknown indexes are ignored
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_WORD_W-1:0] data);
        i_cfg_we    = 1'b1;
        i_cfg_idx   = idx;
        i_cfg_wdata = data;
        @(negedge i_clk);
        i_cfg_we    = 1'b0;
        i_cfg_wdata = {$urandom, $urandom};
        cfg_writes++;
        if (idx == CFG_RADIX) begin
            cur_radix = data[RADIX_W-1:0];
        end else if (idx >= CFG_ALPHA_0 && idx <= CFG_ALPHA_3) begin
            cur_alphabet[ASEL_W'(idx - CFG_IDX_W'(CFG_ALPHA_0))] = data;
        end
    endtask

    // fill the alphabet from text, missing positions become zero bytes
    task automatic load_alphabet(input string text);
        t_alphabet a;
        a = '0;
        for (int k = 0; k < text.len() && k < ALPHA_CHARS; k++) begin
            a[k / 8][(k % 8) * CHAR_W +: CHAR_W] = text[k];
        end
        for (int w = 0; w < ALPHA_WORDS; w++) begin
            write_reg(CFG_IDX_W'(int'(CFG_ALPHA_0) + w), a[w]);
        end
    endtask

    // mostly back-to-back or short gaps, now and then a long one
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (burst_mode || roll < 45) begin
            return 0;
        end
        if (roll < 85) begin
            return $urandom_range(1, 3);
        end
        if (roll < 96) begin
            return $urandom_range(4, 12);
        end
        return $urandom_range(20, 40);
    endfunction

    // one command transaction; called and returns at a falling edge
    task automatic send_value(input logic signed [VALUE_BITS-1:0] v);
        int gap;
        gap = pick_gap();
        // the gap counts idle cycles, so it lands after the block frees up
        while (gap > 0) begin
            @(negedge i_clk);
            if (!busy) begin
                gap--;
            end
        end
        start   = 1'b1;
        i_value = v;
        do begin
            @(posedge i_clk);
        end while (busy !== 1'b0);
        queue_digits(v);
        values_sent++;
        @(negedge i_clk);
        start   = 1'b0;
        i_value = $urandom;
    endtask

    // every character out, block not busy, then a short settle
    task automatic wait_idle();
        while (pending_chars.size() != 0 || busy !== 1'b0) begin
            @(negedge i_clk);
        end
        repeat (4) @(negedge i_clk);
    endtask

    // values aimed at digit-count boundaries, small magnitudes and range ends
    function automatic logic signed [VALUE_BITS-1:0] pick_value();
        longint p;
        logic signed [VALUE_BITS-1:0] v;
        case ($urandom_range(0, 5))
            0: begin
                v = $urandom_range(0, 3 * digit_base());
            end
            1: begin
                // power of the radix, or one above or below it
                p = 1;
                repeat ($urandom_range(1, VALUE_BITS)) begin
                    if (p * digit_base() < (longint'(1) << (VALUE_BITS - 1))) begin
                        p = p * digit_base();
                    end
                end
                v = VALUE_BITS'(p + $urandom_range(0, 2) - 1);
            end
            2: begin
                v = {1'b1, {(VALUE_BITS-1){1'b0}}} + $urandom_range(0, 3);
            end
            3: begin
                v = {1'b0, {(VALUE_BITS-1){1'b1}}} - $urandom_range(0, 3);
            end
            default: begin
                v = $urandom;
            end
        endcase
        if ($urandom_range(0, 1) && v != {1'b1, {(VALUE_BITS-1){1'b0}}}) begin
            v = -v;
        end
        return v;
    endfunction

    // checker: every strobed character against the oldest prediction
    always @(posedge i_clk) begin
        t_char_exp want;
        if (i_rst_n && o_valid) begin
            chars_seen++;
            if (pending_chars.size() == 0) begin
                report_mismatch($sformatf("unexpected character 0x%02h last=%0b",
                                          o_character, o_last));
            end else begin
                want = pending_chars.pop_front();
                if (o_character !== want.ch) begin
                    report_mismatch($sformatf("character 0x%02h, want 0x%02h",
                                              o_character, want.ch));
                end
                if (o_last !== want.last) begin
                    report_mismatch($sformatf("last %0b on 0x%02h, want %0b",
                                              o_last, o_character, want.last));
                end
            end
        end
    end

    // watchdog: restarts on every accepted command or character
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_valid) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog expired after %0d quiet cycles", quiet_cycles);
            $display("tb_integer_to_radix_digits_top: errors");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // reset configuration: decimal with the stock digits
    task automatic test_reset_defaults();
        send_value(0);
        send_value(1);
        send_value(-1);
        send_value(10);
        send_value(-1234567890);
        send_value({1'b0, {(VALUE_BITS-1){1'b1}}});
        send_value({1'b1, {(VALUE_BITS-1){1'b0}}});
    endtask

    // radix ends, clamping of illegal radix values, custom and repeated alphabets
    task automatic test_radix_extremes();
        wait_idle();
        load_alphabet("0123456789abcdefghijklmnopqrstuv");
        write_reg(CFG_RADIX, CFG_WORD_W'(2));
        // most negative value in binary: the longest transaction, 33 characters
        send_value({1'b1, {(VALUE_BITS-1){1'b0}}});
        send_value({1'b0, {(VALUE_BITS-1){1'b1}}});
        wait_idle();
        write_reg(CFG_RADIX, CFG_WORD_W'(MAX_RADIX));
        send_value({1'b1, {(VALUE_BITS-1){1'b0}}});
        send_value(-1);
        send_value(31);
        send_value(0);
        // radix 0 and 1 behave as 2
        wait_idle();
        write_reg(CFG_RADIX, '0);
        send_value(5);
        wait_idle();
        write_reg(CFG_RADIX, CFG_WORD_W'(1));
        send_value(-6);
        // radix above the maximum behaves as the maximum
        wait_idle();
        write_reg(CFG_RADIX, '1);
        send_value(-1000000);
        wait_idle();
        write_reg(CFG_RADIX, CFG_WORD_W'(MAX_RADIX + 1));
        send_value(33);
        // an alphabet with repeated characters, checked like any other
        wait_idle();
        load_alphabet("aaaabbbbccccddddeeeeffffgggghhhh");
        write_reg(CFG_RADIX, CFG_WORD_W'(16));
        send_value(32'h0123_4567);
        // writes to unused indexes must not disturb anything
        wait_idle();
        for (int k = int'(CFG_ALPHA_3) + 1; k < (1 << CFG_IDX_W); k++) begin
            write_reg(CFG_IDX_W'(k), {$urandom, $urandom});
        end
        send_value(-255);
    endtask

    // random phases, each with its own radix and alphabet
    task automatic test_random_values();
        logic [RADIX_W-1:0] rdx;
        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            wait_idle();
            case (phase)
                0: rdx = RADIX_W'(2);
                1: rdx = RADIX_W'(MAX_RADIX);
                2: rdx = RADIX_W'($urandom_range(0, 1));
                3: rdx = RADIX_W'($urandom_range(MAX_RADIX + 1, (1 << RADIX_W) - 1));
                default: begin
                    if ($urandom_range(0, 3) == 0) begin
                        rdx = RADIX_W'($urandom);
                    end else begin
                        rdx = RADIX_W'($urandom_range(2, MAX_RADIX));
                    end
                end
            endcase
            write_reg(CFG_RADIX, CFG_WORD_W'(rdx));
            for (int w = 0; w < ALPHA_WORDS; w++) begin
                if (phase < 2 || $urandom_range(0, 1)) begin
                    write_reg(CFG_IDX_W'(int'(CFG_ALPHA_0) + w), {$urandom, $urandom});
                end
            end
            if ($urandom_range(0, 3) == 0) begin
                write_reg(CFG_IDX_W'($urandom_range(int'(CFG_ALPHA_3) + 1,
                                                    (1 << CFG_IDX_W) - 1)),
                          {$urandom, $urandom});
            end
            // every fourth phase runs with no idle cycles at all
            burst_mode = (phase % 4 == 3);
            repeat (VALUES_PER_PHASE) send_value(pick_value());
        end
        burst_mode = 1'b0;
    endtask

    initial begin
        i_rst_n      = 1'b0;
        start        = 1'b0;
        i_value      = '0;
        i_cfg_we     = 1'b0;
        i_cfg_idx    = CFG_RADIX;
        i_cfg_wdata  = '0;
        error_count  = 0;
        values_sent  = 0;
        chars_seen   = 0;
        cfg_writes   = 0;
        quiet_cycles = 0;
        burst_mode   = 1'b0;
        cur_radix    = RADIX_RESET;
        cur_alphabet = ALPHA_RESET;

        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_reset_defaults();
        test_radix_extremes();
        test_random_values();

        // drain, then leave room for anything spurious to show up
        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("converted %0d values into %0d characters across %0d register writes",
                 values_sent, chars_seen, cfg_writes);
        $display("radix ends, clamped radix codes, custom alphabets and range ends included");
        if (error_count == 0) begin
            $display("tb_integer_to_radix_digits_top: clean");
        end else begin
            $display("%0d mismatches", error_count);
            $display("tb_integer_to_radix_digits_top: errors");
        end
        $finish;
    end

endmodule
